### rtl/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// Shared types and constants for the sorted priority list block.
// ----------------------------------------------------------------------------
package psl_pkg;

    localparam int PRI_W     = 8;
    localparam int IN_ID_W   = 16;
    localparam int IN_CLS_W  = 8;
    localparam int POS_W     = 4;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_REPLACED = 3'd1,
        ST_PRESENT  = 3'd2,
        ST_EXCL     = 3'd3,
        ST_REMOVED  = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_FULL     = 3'd6
    } psl_status_t;

    // flags from the entry compare unit
    typedef struct packed {
        logic id_eq;
        logic cls_eq;
        logic pri_le;
        logic pri_eq;
    } psl_cmp_t;

endpackage

### rtl/psl_mem.sv
// ----------------------------------------------------------------------------
// psl_mem
// List storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psl_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/psl_cmp.sv
// ----------------------------------------------------------------------------
// psl_cmp
// Entry compare unit: checks one stored entry against the request.
// ----------------------------------------------------------------------------
module psl_cmp #(
    parameter int ID_BITS    = 16,
    parameter int CLASS_BITS = 8
) (
    input  logic [ID_BITS-1:0]         entry_id,
    input  logic [CLASS_BITS-1:0]      entry_cls,
    input  logic [psl_pkg::PRI_W-1:0]  entry_pri,
    input  logic [ID_BITS-1:0]         req_id,
    input  logic [CLASS_BITS-1:0]      req_cls,
    input  logic [psl_pkg::PRI_W-1:0]  req_pri,
    output psl_pkg::psl_cmp_t          flags
);

    always_comb begin
        flags.id_eq  = (entry_id == req_id);
        flags.cls_eq = (entry_cls == req_cls);
        flags.pri_le = (req_pri <= entry_pri);
        flags.pri_eq = (req_pri == entry_pri);
    end

endmodule

### rtl/priority_sorted_list_insert_remove_top.sv
// ----------------------------------------------------------------------------
// priority_sorted_list_insert_remove_top
// Sorted priority list with add and remove commands; the scan reads one entry per cycle.
// ----------------------------------------------------------------------------
// Steps: a scan of the listed entries, a decision, a shift pass when entries
// must move, the final write for an insert into the list, and then the
// registered result, which waits for m_tready. One item at a time: s_tready
// is high only in idle, as the single memory port and compare unit serve it.
// Reset empties the list at once (count cleared, no sweep).
// ----------------------------------------------------------------------------
module priority_sorted_list_insert_remove_top #(
    parameter int DEPTH      = 16,
    parameter int ID_BITS    = 16,
    parameter int CLASS_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_id[15:0], class_tag[23:16], priority_req[31:24], exclusive[32], zero pad
    input  logic [psl_pkg::S_TDATA_W-1:0]     s_tdata,
    // command[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[2:0], position[6:3], zero pad
    output logic [psl_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = psl_pkg::PRI_W;
    localparam int EW = ID_BITS + CLASS_BITS + PW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_PLACE  = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // request
    logic                 cmd_reg, cmd_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [CLASS_BITS-1:0] cls_reg, cls_next;
    logic [PW-1:0]        pri_reg, pri_next;
    logic                 excl_reg, excl_next;

    // list control
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rd_vld_reg, rd_vld_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;

    // scan results
    logic          hit_id_reg, hit_id_next;
    logic [IW-1:0] id_idx_reg, id_idx_next;
    logic          hit_cls_reg, hit_cls_next;
    logic [IW-1:0] cls_idx_reg, cls_idx_next;
    logic          hit_ins_reg, hit_ins_next;
    logic [IW-1:0] ins_idx_reg, ins_idx_next;
    logic          ins_eq_reg, ins_eq_next;

    // result
    psl_pkg::psl_status_t res_status_reg, res_status_next;
    logic [IW-1:0]        res_pos_reg, res_pos_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [psl_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // memory port
    logic          mem_rd_en;
    logic [IW-1:0] mem_rd_addr;
    logic [EW-1:0] mem_rd_data;
    logic          mem_wr_en;
    logic [IW-1:0] mem_wr_addr;
    logic [EW-1:0] mem_wr_data;

    psl_pkg::psl_cmp_t cmp_flags;

    // input fields, cut or widened to the stored widths
    logic [ID_BITS+psl_pkg::IN_ID_W-1:0]     in_id_wide;
    logic [CLASS_BITS+psl_pkg::IN_CLS_W-1:0] in_cls_wide;
    logic [IW+psl_pkg::POS_W-1:0]            pos_wide;

    assign in_id_wide  = {{ID_BITS{1'b0}}, s_tdata[15:0]};
    assign in_cls_wide = {{CLASS_BITS{1'b0}}, s_tdata[23:16]};
    assign pos_wide    = {{psl_pkg::POS_W{1'b0}}, res_pos_reg};

    psl_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    psl_cmp #(
        .ID_BITS    (ID_BITS),
        .CLASS_BITS (CLASS_BITS)
    ) u_cmp (
        .entry_id  (mem_rd_data[EW-1 -: ID_BITS]),
        .entry_cls (mem_rd_data[PW +: CLASS_BITS]),
        .entry_pri (mem_rd_data[PW-1:0]),
        .req_id    (id_reg),
        .req_cls   (cls_reg),
        .req_pri   (pri_reg),
        .flags     (cmp_flags)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        cls_next        = cls_reg;
        pri_next        = pri_reg;
        excl_next       = excl_reg;
        count_next      = count_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_id_next     = hit_id_reg;
        id_idx_next     = id_idx_reg;
        hit_cls_next    = hit_cls_reg;
        cls_idx_next    = cls_idx_reg;
        hit_ins_next    = hit_ins_reg;
        ins_idx_next    = ins_idx_reg;
        ins_eq_next     = ins_eq_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = cnt_reg[IW-1:0];
        mem_wr_en       = 1'b0;
        mem_wr_addr     = rd_idx_reg;
        mem_wr_data     = mem_rd_data;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next     = s_tuser;
                    id_next      = in_id_wide[ID_BITS-1:0];
                    cls_next     = in_cls_wide[CLASS_BITS-1:0];
                    pri_next     = s_tdata[31:24];
                    excl_next    = s_tdata[32];
                    cnt_next     = '0;
                    hit_id_next  = 1'b0;
                    hit_cls_next = 1'b0;
                    hit_ins_next = 1'b0;
                    ins_eq_next  = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cnt_reg < count_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = cnt_reg[IW-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg[IW-1:0];
                    cnt_next    = cnt_reg + 1'b1;
                end
                // keep only the first match of each kind
                if (rd_vld_reg) begin
                    if (cmp_flags.id_eq && !hit_id_reg) begin
                        hit_id_next = 1'b1;
                        id_idx_next = rd_idx_reg;
                    end
                    if (cmp_flags.cls_eq && !hit_cls_reg) begin
                        hit_cls_next = 1'b1;
                        cls_idx_next = rd_idx_reg;
                    end
                    if (cmp_flags.pri_le && !hit_ins_reg) begin
                        hit_ins_next = 1'b1;
                        ins_idx_next = rd_idx_reg;
                        ins_eq_next  = cmp_flags.pri_eq;
                    end
                end
                if (cnt_reg >= count_reg && !rd_vld_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                res_pos_next = '0;
                state_next   = S_RESP;
                if (cmd_reg == psl_pkg::CMD_REMOVE) begin
                    if (hit_id_reg) begin
                        res_status_next = psl_pkg::ST_REMOVED;
                        res_pos_next    = id_idx_reg;
                        if ({1'b0, id_idx_reg} + 1'b1 < {1'b0, count_reg}) begin
                            cnt_next   = CW'({1'b0, id_idx_reg} + 1'b1);
                            state_next = S_SHIFT;
                        end else begin
                            count_next = count_reg - 1'b1;
                        end
                    end else begin
                        res_status_next = psl_pkg::ST_NOTFOUND;
                    end
                end else if (hit_id_reg) begin
                    res_status_next = psl_pkg::ST_PRESENT;
                end else if (hit_cls_reg) begin
                    // class replacement keeps its slot, even out of order
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = cls_idx_reg;
                    mem_wr_data     = {id_reg, cls_reg, pri_reg};
                    res_status_next = psl_pkg::ST_REPLACED;
                    res_pos_next    = cls_idx_reg;
                end else if (hit_ins_reg && excl_reg && ins_eq_reg) begin
                    res_status_next = psl_pkg::ST_EXCL;
                end else if (count_reg == CW'(DEPTH)) begin
                    res_status_next = psl_pkg::ST_FULL;
                end else if (hit_ins_reg) begin
                    res_status_next = psl_pkg::ST_ADDED;
                    res_pos_next    = ins_idx_reg;
                    cnt_next        = count_reg;
                    state_next      = S_SHIFT;
                end else begin
                    // append at the tail
                    mem_wr_en       = 1'b1;
                    mem_wr_addr     = count_reg[IW-1:0];
                    mem_wr_data     = {id_reg, cls_reg, pri_reg};
                    res_status_next = psl_pkg::ST_ADDED;
                    res_pos_next    = count_reg[IW-1:0];
                    count_next      = count_reg + 1'b1;
                end
            end
            S_SHIFT: begin
                if (cmd_reg == psl_pkg::CMD_REMOVE) begin
                    // move entries down over the removed slot
                    if (cnt_reg < count_reg) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = cnt_reg[IW-1:0];
                        rd_vld_next = 1'b1;
                        rd_idx_next = cnt_reg[IW-1:0];
                        cnt_next    = cnt_reg + 1'b1;
                    end
                    if (rd_vld_reg) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = rd_idx_reg - 1'b1;
                    end
                    if (cnt_reg >= count_reg && !rd_vld_reg) begin
                        count_next = count_reg - 1'b1;
                        state_next = S_RESP;
                    end
                end else begin
                    // open a gap at the insert point, tail first
                    if (cnt_reg > {1'b0, ins_idx_reg}) begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IW'(cnt_reg - 1'b1);
                        rd_vld_next = 1'b1;
                        rd_idx_next = IW'(cnt_reg - 1'b1);
                        cnt_next    = cnt_reg - 1'b1;
                    end
                    if (rd_vld_reg) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = rd_idx_reg + 1'b1;
                    end
                    if (cnt_reg <= {1'b0, ins_idx_reg} && !rd_vld_reg) begin
                        state_next = S_PLACE;
                    end
                end
            end
            S_PLACE: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ins_idx_reg;
                mem_wr_data = {id_reg, cls_reg, pri_reg};
                count_next  = count_reg + 1'b1;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, pos_wide[psl_pkg::POS_W-1:0], res_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        id_reg         <= id_next;
        cls_reg        <= cls_next;
        pri_reg        <= pri_next;
        excl_reg       <= excl_next;
        cnt_reg        <= cnt_next;
        rd_idx_reg     <= rd_idx_next;
        hit_id_reg     <= hit_id_next;
        id_idx_reg     <= id_idx_next;
        hit_cls_reg    <= hit_cls_next;
        cls_idx_reg    <= cls_idx_next;
        hit_ins_reg    <= hit_ins_next;
        ins_idx_reg    <= ins_idx_next;
        ins_eq_reg     <= ins_eq_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_tdata_reg    <= m_tdata_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond list depth");

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_SCAN) |-> !mem_wr_en)
        else $error("list written outside an update");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> ({1'b0, rd_idx_reg} < count_reg))
        else $error("read of a slot beyond the list");

    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && count_reg != $past(count_reg)) |->
        ($past(state_reg) == S_DECIDE || $past(state_reg) == S_SHIFT ||
         $past(state_reg) == S_PLACE))
        else $error("entry count changed outside an update");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result raised without a finished item");

endmodule
